### rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants for the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned BB_W    = 4;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Low half of the multiplicative hash constant 0x9E3779B1.
  localparam logic [15:0] HASH_MUL_LO = 16'h79B1;

  localparam int unsigned BB_RESET = 8;

  typedef enum logic [0:0] {
    CFG_BUCKET_BITS = 1'b0
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HREAD,
    S_HCHK,
    S_NCHK,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] node_slot;
  } req_t;

  typedef struct packed {
    logic              found;
    logic              slot_used;
    logic [SLOT_W-1:0] removed_slot;
  } rsp_t;

endpackage

### rtl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// chained_hash_set
// Set of keys in a chained hash table with a multiplicative hash, held in a
// bucket head memory and a node memory.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   req_t  (req_type, key, node_slot)
//   out       output     out_valid_o / out_stall_i rsp_t  (found, slot_used, removed_slot)
//   config    input      APB write / read          bucket_bits at address 0
//
// An item steps through the head read, the head check, one node check per
// chain node visited, the update and the result; each step of the walk
// waits on the registered read of the node memory. An unknown request type
// goes straight to the result. After reset and after each bucket_bits write,
// a clearing pass writes null to all 2**floor(log2(MAX_BUCKETS)) bucket heads.
// A stalled output holds its item while the next item is being processed.
// ----------------------------------------------------------------------------
module chained_hash_set
  import chs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned NODES       = 1024,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_data_o
);

  localparam int unsigned BB_MAX = $clog2(MAX_BUCKETS + 1) - 1;
  localparam int unsigned HEADS  = 2 ** BB_MAX;
  localparam int unsigned HW     = (BB_MAX > 0) ? BB_MAX : 1;
  localparam int unsigned LW     = $clog2(NODES + 1);
  localparam int unsigned NW     = $clog2(NODES);
  localparam int unsigned NDW    = LW + KEY_BITS;
  localparam int unsigned BB_RST = (BB_RESET > BB_MAX) ? BB_MAX : BB_RESET;

  logic [BB_W-1:0] bb_q, bb_d;
  logic            cfg_sel;
  logic            cfg_wr;

  logic            head_we;
  logic [HW-1:0]   head_waddr;
  logic [LW-1:0]   head_wdata;
  logic [HW-1:0]   head_raddr;
  logic [LW-1:0]   head_rdata;
  logic            node_we;
  logic [NW-1:0]   node_waddr;
  logic [NDW-1:0]  node_wdata;
  logic [NW-1:0]   node_raddr;
  logic [NDW-1:0]  node_rdata;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1:2] == CFG_BUCKET_BITS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? PDATA_W'(bb_q) : '0;

  always_comb begin
    bb_d = bb_q;
    if (cfg_wr) begin
      if (32'(pwdata[BB_W-1:0]) > 32'(BB_MAX)) begin
        bb_d = BB_W'(BB_MAX);
      end else begin
        bb_d = pwdata[BB_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q <= BB_W'(BB_RST);
    end else begin
      bb_q <= bb_d;
    end
  end

  chs_ctrl #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .NODES       (NODES),
    .KEY_BITS    (KEY_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bb_i         (bb_q),
    .clr_start_i  (cfg_wr),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .head_we_o    (head_we),
    .head_waddr_o (head_waddr),
    .head_wdata_o (head_wdata),
    .head_raddr_o (head_raddr),
    .head_rdata_i (head_rdata),
    .node_we_o    (node_we),
    .node_waddr_o (node_waddr),
    .node_wdata_o (node_wdata),
    .node_raddr_o (node_raddr),
    .node_rdata_i (node_rdata)
  );

  chs_ram #(
    .WIDTH (LW),
    .DEPTH (HEADS),
    .AW    (HW)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  chs_ram #(
    .WIDTH (NDW),
    .DEPTH (NODES),
    .AW    (NW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

endmodule

### rtl/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl
// Request sequencer: hashes the key, walks the bucket chain through the
// head and node memories, applies the update and holds the result item.
// ----------------------------------------------------------------------------
module chs_ctrl
  import chs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned NODES       = 1024,
  parameter int unsigned KEY_BITS    = 32,
  localparam int unsigned BB_MAX     = $clog2(MAX_BUCKETS + 1) - 1,
  localparam int unsigned HEADS      = 2 ** BB_MAX,
  localparam int unsigned HW         = (BB_MAX > 0) ? BB_MAX : 1,
  localparam int unsigned LW         = $clog2(NODES + 1),
  localparam int unsigned NW         = $clog2(NODES),
  localparam int unsigned NDW        = LW + KEY_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [BB_W-1:0] bb_i,
  input  logic            clr_start_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  req_t            in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsp_t            out_data_o,
  output logic            head_we_o,
  output logic [HW-1:0]   head_waddr_o,
  output logic [LW-1:0]   head_wdata_o,
  output logic [HW-1:0]   head_raddr_o,
  input  logic [LW-1:0]   head_rdata_i,
  output logic            node_we_o,
  output logic [NW-1:0]   node_waddr_o,
  output logic [NDW-1:0]  node_wdata_o,
  output logic [NW-1:0]   node_raddr_o,
  input  logic [NDW-1:0]  node_rdata_i
);

  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  state_e              state_q, state_d;
  logic [HW-1:0]       clr_q, clr_d;
  logic [1:0]          req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [HW-1:0]       idx_q, idx_d;
  logic [LW-1:0]       head_q, head_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic                prev_vld_q, prev_vld_d;
  logic [NW-1:0]       prev_q, prev_d;
  logic [KEY_BITS-1:0] prev_key_q, prev_key_d;
  logic [LW-1:0]       at_link_q, at_link_d;
  logic                hit_q, hit_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  rsp_t                res_q, res_d;
  logic                out_vld_q, out_vld_d;
  rsp_t                out_q, out_d;

  logic [KEY_BITS-1:0] key_in;
  logic [15:0]         prod;
  logic [HW-1:0]       mask;
  logic [LW-1:0]       rd_link;
  logic [KEY_BITS-1:0] rd_key;
  logic                slot_ok;

  assign key_in  = in_data_i.key[KEY_BITS-1:0];
  assign prod    = 16'(key_in) * HASH_MUL_LO;
  assign rd_link = node_rdata_i[NDW-1:KEY_BITS];
  assign rd_key  = node_rdata_i[KEY_BITS-1:0];
  assign slot_ok = 32'(slot_q) < 32'(NODES);

  always_comb begin
    for (int i = 0; i < HW; i++) begin
      mask[i] = 32'(i) < 32'(bb_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    slot_q     <= slot_d;
    idx_q      <= idx_d;
    head_q     <= head_d;
    cur_q      <= cur_d;
    prev_vld_q <= prev_vld_d;
    prev_q     <= prev_d;
    prev_key_q <= prev_key_d;
    at_link_q  <= at_link_d;
    hit_q      <= hit_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    req_d      = req_q;
    key_d      = key_q;
    slot_d     = slot_q;
    idx_d      = idx_q;
    head_d     = head_q;
    cur_d      = cur_q;
    prev_vld_d = prev_vld_q;
    prev_d     = prev_q;
    prev_key_d = prev_key_q;
    at_link_d  = at_link_q;
    hit_d      = hit_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;

    head_we_o    = 1'b0;
    head_waddr_o = clr_q;
    head_wdata_o = NULL_LINK;
    head_raddr_o = idx_q;
    node_we_o    = 1'b0;
    node_waddr_o = cur_q;
    node_wdata_o = {head_q, key_q};
    node_raddr_o = cur_q;

    in_stall_o = (state_q != S_IDLE);

    case (state_q)
      S_CLEAR: begin
        head_we_o = 1'b1;
        clr_d     = clr_q + 1'b1;
        if (clr_q == HW'(HEADS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i.req_type;
          key_d  = key_in;
          slot_d = in_data_i.node_slot;
          idx_d  = prod[HW-1:0] & mask;
          if (in_data_i.req_type inside {REQ_INSERT, REQ_LOOKUP, REQ_DELETE}) begin
            state_d = S_HREAD;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_HREAD: begin
        state_d = S_HCHK;
      end
      S_HCHK: begin
        head_d     = head_rdata_i;
        cnt_d      = '0;
        prev_vld_d = 1'b0;
        hit_d      = 1'b0;
        if (head_rdata_i < NULL_LINK) begin
          cur_d        = NW'(head_rdata_i);
          node_raddr_o = NW'(head_rdata_i);
          state_d      = S_NCHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_NCHK: begin
        if (rd_key == key_q) begin
          hit_d     = 1'b1;
          at_link_d = rd_link;
          state_d   = S_FIN;
        end else begin
          prev_vld_d = 1'b1;
          prev_d     = cur_q;
          prev_key_d = rd_key;
          cnt_d      = cnt_q + 1'b1;
          if (rd_link < NULL_LINK && cnt_q != NW'(NODES - 1)) begin
            cur_d        = NW'(rd_link);
            node_raddr_o = NW'(rd_link);
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        res_d.found        = hit_q;
        res_d.slot_used    = 1'b0;
        res_d.removed_slot = '0;
        case (req_q)
          REQ_INSERT: begin
            if (!hit_q && slot_ok) begin
              node_we_o       = 1'b1;
              node_waddr_o    = NW'(slot_q);
              node_wdata_o    = {head_q, key_q};
              head_we_o       = 1'b1;
              head_waddr_o    = idx_q;
              head_wdata_o    = LW'(slot_q);
              res_d.slot_used = 1'b1;
            end
          end
          REQ_DELETE: begin
            if (hit_q) begin
              if (prev_vld_q) begin
                node_we_o    = 1'b1;
                node_waddr_o = prev_q;
                node_wdata_o = {at_link_q, prev_key_q};
              end else begin
                head_we_o    = 1'b1;
                head_waddr_o = idx_q;
                head_wdata_o = at_link_q;
              end
              res_d.removed_slot = SLOT_W'(cur_q);
            end
          end
          default: begin
          end
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clr_start_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the chained hash set, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker
  import chs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic               pready,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rsp_t               out_data_o
);

  // A held result must not change while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result item changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Configuration port not ready.");

  // An insert that linked its slot cannot have found the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.slot_used |-> !out_data_o.found)
    else $error("Slot used although key was present.");

  // A freed slot comes only from a delete that found its key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.removed_slot != '0) |->
      out_data_o.found && !out_data_o.slot_used)
    else $error("Removed slot reported without a hit.");

  // A bucket_bits write starts the head clearing pass, which holds off items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == CFG_BUCKET_BITS)
      |=> in_stall_o)
    else $error("Item accepted right after a bucket_bits write.");

endmodule

bind chained_hash_set chs_checker u_chs_checker (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained hash set. A driver feeds insert, lookup
// and delete requests from a queue, an in-bench predictor of the bucket heads
// and node store computes each expected response when a request is accepted,
// and a monitor compares every response field by field. Bucket counts change
// between phases over the APB port, and both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import chs_pkg::*;

  localparam int unsigned MAX_BUCKETS = 256;
  localparam int unsigned NODES       = 1024;
  localparam int unsigned BB_MAX      = $clog2(MAX_BUCKETS);
  localparam logic [31:0] HASH_K      = 32'h9E3779B1;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam int          LIVE_CAP    = 48;
  localparam int          CYCLE_LIMIT = 400000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  req_t               in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsp_t               out_data_o;

  chained_hash_set #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .NODES      (NODES),
    .KEY_BITS   (32)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predicted table contents.
  logic [10:0] head_slot [MAX_BUCKETS];
  logic [31:0] node_key  [NODES];
  logic [10:0] node_next [NODES];
  int unsigned bucket_bits_m = BB_RESET;

  // Request and response bookkeeping.
  req_t req_pending [$];
  rsp_t rsp_expected [$];
  bit   req_taken;
  int   idle_pct;
  int   in_gap;
  int   out_gap;
  int   cycles;
  int   n_checked;
  int   n_mismatch;
  int   n_found;
  int   n_linked;
  int   n_unlinked;
  int   n_settings;

  // Generator view of which keys are currently in the set.
  int unsigned live_slot [bit [31:0]];
  bit [31:0]   live_keys [$];
  logic [9:0]  free_slots [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_heads_model();
    foreach (head_slot[i]) head_slot[i] = 11'(NODES);
  endfunction

  function automatic rsp_t hash_set_update(req_t r);
    rsp_t        res;
    logic [31:0] h;
    int unsigned bkt;
    int unsigned cur;
    int unsigned prev;
    int unsigned at;
    int unsigned steps;
    bit          hit;
    res = '0;
    if (r.req_type inside {REQ_INSERT, REQ_LOOKUP, REQ_DELETE}) begin
      h     = r.key * HASH_K;
      bkt   = h & ((32'd1 << bucket_bits_m) - 1);
      cur   = head_slot[bkt];
      prev  = NODES;
      at    = NODES;
      steps = 0;
      hit   = 1'b0;
      while (!hit && cur < NODES && steps < NODES) begin
        if (node_key[cur] == r.key) begin
          hit = 1'b1;
          at  = cur;
        end else begin
          prev = cur;
          cur  = node_next[cur];
          steps++;
        end
      end
      res.found = hit;
      if (hit) n_found++;
      if (r.req_type == REQ_INSERT && !hit && r.node_slot < NODES) begin
        node_key[r.node_slot]  = r.key;
        node_next[r.node_slot] = head_slot[bkt];
        head_slot[bkt]         = 11'(r.node_slot);
        res.slot_used          = 1'b1;
        n_linked++;
      end else if (r.req_type == REQ_DELETE && hit) begin
        if (prev < NODES) node_next[prev] = node_next[at];
        else head_slot[bkt] = node_next[at];
        res.removed_slot = at[SLOT_W-1:0];
        n_unlinked++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    if (n_mismatch < 40) begin
      $display("[%0d] %s: got found=%0b used=%0b removed=%0d, want found=%0b used=%0b removed=%0d",
               cycles, what, got.found, got.slot_used, got.removed_slot,
               want.found, want.slot_used, want.removed_slot);
    end
    n_mismatch++;
  endtask

  // Request driver: a presented item is held until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (req_pending.size() > 0 && idle_pct > 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        in_gap = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (req_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= req_pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response-side stall driver.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      out_gap = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predicts on accepted requests and checks accepted responses.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end else begin
        if (in_valid_i && !in_stall_o) begin
          void'(req_pending.pop_front());
          rsp_expected.push_back(hash_set_update(in_data_i));
          req_taken = 1'b1;
        end
        if (out_valid_o && !out_stall_i) begin
          if (rsp_expected.size() == 0) begin
            report_mismatch("response with nothing expected", out_data_o, '0);
          end else begin
            want = rsp_expected.pop_front();
            n_checked++;
            if (out_data_o.found !== want.found) begin
              report_mismatch("found differs", out_data_o, want);
            end
            if (out_data_o.slot_used !== want.slot_used) begin
              report_mismatch("slot_used differs", out_data_o, want);
            end
            if (out_data_o.removed_slot !== want.removed_slot) begin
              report_mismatch("removed_slot differs", out_data_o, want);
            end
          end
        end
      end
    end
  end

  task automatic queue_req(input logic [1:0] t, input logic [31:0] k, input logic [9:0] s);
    req_pending.push_back('{req_type: t, key: k, node_slot: s});
  endtask

  task automatic drain();
    while (req_pending.size() > 0 || rsp_expected.size() > 0) @(posedge clk_i);
  endtask

  task automatic set_buckets(input logic [3:0] v);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * CFG_BUCKET_BITS);
    pwdata  <= PDATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bucket_bits_m = (v > BB_MAX) ? BB_MAX : v;
    clear_heads_model();
    live_slot.delete();
    live_keys.delete();
    free_slots.delete();
    for (int i = 0; i < NODES; i++) free_slots.push_back(10'(i));
    n_settings++;
  endtask

  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    do begin
      case ($urandom_range(0, 15))
        0:       k = 32'h0000_0000;
        1:       k = 32'hFFFF_FFFF;
        default: k = $urandom;
      endcase
    end while (live_slot.exists(k));
    return k;
  endfunction

  task automatic run_random(input int n, input int pct);
    int          made;
    int          idx;
    int          r;
    logic [31:0] k;
    logic [9:0]  s;
    idle_pct = pct;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_req(REQ_UNKNOWN, $urandom, 10'($urandom));
      end else if (r < 44) begin
        if (live_keys.size() > 0 &&
            (live_keys.size() >= LIVE_CAP || $urandom_range(0, 4) == 0)) begin
          queue_req(REQ_INSERT, live_keys[$urandom_range(0, live_keys.size() - 1)],
                    10'($urandom));
        end else begin
          k   = fresh_key();
          idx = $urandom_range(0, free_slots.size() - 1);
          s   = free_slots[idx];
          free_slots.delete(idx);
          live_slot[k] = s;
          live_keys.push_back(k);
          queue_req(REQ_INSERT, k, s);
        end
      end else if (r < 74) begin
        if (live_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else begin
          k = fresh_key();
        end
        queue_req(REQ_LOOKUP, k, 10'($urandom));
      end else begin
        if (live_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, live_keys.size() - 1);
          k   = live_keys[idx];
          free_slots.push_back(10'(live_slot[k]));
          live_slot.delete(k);
          live_keys.delete(idx);
        end else begin
          k = fresh_key();
        end
        queue_req(REQ_DELETE, k, 10'($urandom));
      end
      if (r >= 4) made++;
    end
  endtask

  initial begin
    clear_heads_model();
    idle_pct = 25;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, duplicate insert, extreme keys and slots, unknown type.
    queue_req(REQ_LOOKUP, 32'h0000_0000, 10'd0);
    queue_req(REQ_INSERT, 32'h0000_0000, 10'd0);
    queue_req(REQ_INSERT, 32'h0000_0000, 10'd5);
    queue_req(REQ_LOOKUP, 32'h0000_0000, 10'd0);
    queue_req(REQ_INSERT, 32'hFFFF_FFFF, 10'd1023);
    queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
    queue_req(REQ_DELETE, 32'hFFFF_FFFF, 10'd0);
    queue_req(REQ_DELETE, 32'hFFFF_FFFF, 10'd1023);
    queue_req(REQ_DELETE, 32'h0000_0000, 10'd0);
    queue_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 10'd1023);
    queue_req(REQ_UNKNOWN, 32'h0000_0000, 10'd0);

    // A single bucket: unlink from middle, head and tail, then a looped chain.
    set_buckets(4'd0);
    queue_req(REQ_INSERT, 32'd1, 10'd1);
    queue_req(REQ_INSERT, 32'd2, 10'd2);
    queue_req(REQ_INSERT, 32'd3, 10'd3);
    queue_req(REQ_DELETE, 32'd2, 10'd0);
    queue_req(REQ_DELETE, 32'd3, 10'd0);
    queue_req(REQ_DELETE, 32'd1, 10'd0);
    queue_req(REQ_INSERT, 32'hA5A5_A5A5, 10'd7);
    queue_req(REQ_INSERT, 32'h5A5A_5A5A, 10'd7);
    queue_req(REQ_LOOKUP, 32'hA5A5_A5A5, 10'd0);
    queue_req(REQ_LOOKUP, 32'h5A5A_5A5A, 10'd0);
    queue_req(REQ_INSERT, 32'h1234_5678, 10'd9);

    // An oversized setting saturates to the largest bucket count.
    set_buckets(4'd15);
    run_random(140, 30);
    set_buckets(4'd1);
    run_random(120, 50);
    set_buckets(4'd0);
    run_random(100, 20);
    set_buckets(4'd4);
    run_random(120, 0);
    set_buckets(4'd12);
    run_random(120, 40);
    set_buckets(4'd2);
    run_random(120, 30);
    set_buckets(4'd8);
    run_random(110, 0);

    drain();
    repeat (64) @(posedge clk_i);
    $display("Checked %0d responses across %0d bucket settings.", n_checked, n_settings + 1);
    $display("Keys found %0d times, %0d nodes linked, %0d nodes unlinked.",
             n_found, n_linked, n_unlinked);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chs_ctrl.sv
rtl/chained_hash_set.sv
rtl/chs_checker.sv
dv/testbench.sv
